@@ rtl/tic_pkg.sv @@
// Shared types, constants and helpers of the triangle incenter pipeline.
package tic_pkg;

  typedef struct packed {
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic signed [31:0] x2;
    logic signed [31:0] y2;
    logic signed [31:0] x3;
    logic signed [31:0] y3;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic               fell_back;
    logic               saturated;
  } out_word_t;

  typedef enum logic [0:0] {
    REG_MIN_EDGE = 1'b0,
    REG_MIN_DET  = 1'b1
  } reg_idx_e;

  localparam int unsigned MIN_EDGE_W = 16;
  localparam int unsigned MIN_DET_W  = 30;

  // Division by three as a multiply by ceil(2^36 / 3), exact below 2^35.
  localparam logic [34:0] RECIP3       = 35'd22906492246;
  localparam int unsigned RECIP3_SHIFT = 36;

  localparam logic [31:0] ONE_Q30  = 32'd1073741824;
  localparam logic [40:0] QUOT_CAP = 41'h100_0000_0000;

  // Divides by 2^30 and rounds toward zero.
  function automatic logic signed [35:0] trunc_q30(input logic signed [65:0] v);
    logic signed [65:0] adj;
    adj = v + $signed({36'd0, {30{v[65]}}});
    return adj[65:30];
  endfunction

endpackage

@@ rtl/tic_delay.sv @@
// Enabled delay line that carries a word and its valid bit.
module tic_delay #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         vld_i,
  input  logic [W-1:0] data_i,
  output logic         vld_o,
  output logic [W-1:0] data_o
);

  logic         vld_q  [DEPTH];
  logic [W-1:0] data_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en_i) begin
      vld_q[0] <= vld_i;
      for (int i = 1; i < DEPTH; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q[0] <= data_i;
      for (int i = 1; i < DEPTH; i++) begin
        data_q[i] <= data_q[i-1];
      end
    end
  end

  assign vld_o  = vld_q[DEPTH-1];
  assign data_o = data_q[DEPTH-1];

endmodule

@@ rtl/tic_isqrt.sv @@
// Pipelined floor square root, one result bit per stage.
module tic_isqrt #(
  parameter int unsigned ROOT_W = 32
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [2*ROOT_W-1:0]   rad_i,
  output logic [ROOT_W-1:0]     root_o
);

  localparam int unsigned RadW = 2 * ROOT_W;
  localparam int unsigned RemW = ROOT_W + 2;

  logic [RemW-1:0]   rem_q  [ROOT_W+1];
  logic [ROOT_W-1:0] root_q [ROOT_W+1];
  logic [RadW-1:0]   rad_q  [ROOT_W];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      rad_q[0]  <= rad_i;
    end
  end

  for (genvar s = 1; s <= ROOT_W; s++) begin : g_step
    logic [RemW+1:0] pull;
    logic [RemW+1:0] trial;
    logic            take;

    always_comb begin
      pull  = {rem_q[s-1], rad_q[s-1][RadW-1 -: 2]};
      trial = {2'b00, root_q[s-1], 2'b01};
      take  = (pull >= trial);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= take ? RemW'(pull - trial) : pull[RemW-1:0];
        root_q[s] <= {root_q[s-1][ROOT_W-2:0], take};
      end
    end

    if (s < ROOT_W) begin : g_rad
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rad_q[s] <= {rad_q[s-1][RadW-3:0], 2'b00};
        end
      end
    end
  end

  assign root_o = root_q[ROOT_W];

endmodule

@@ rtl/tic_udiv.sv @@
// Pipelined restoring unsigned divider, one quotient bit per stage.
module tic_udiv #(
  parameter int unsigned NUM_W = 62,
  parameter int unsigned DEN_W = 33,
  parameter int unsigned QUO_W = 32
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o,
  output logic             ovf_o
);

  localparam int unsigned HiW = NUM_W - QUO_W;

  logic [HiW-1:0]   num_hi;
  logic             ovf_in;

  logic [DEN_W-1:0] rem_q [QUO_W+1];
  logic [QUO_W-1:0] quo_q [QUO_W+1];
  logic             ovf_q [QUO_W+1];
  logic [QUO_W-1:0] low_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];

  // The quotient does not fit when the upper numerator part reaches the divisor.
  assign num_hi = num_i[NUM_W-1:QUO_W];
  assign ovf_in = (DEN_W'(num_hi) >= den_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= ovf_in ? '0 : DEN_W'(num_hi);
      quo_q[0] <= '0;
      ovf_q[0] <= ovf_in;
      low_q[0] <= num_i[QUO_W-1:0];
      den_q[0] <= den_i;
    end
  end

  for (genvar s = 1; s <= QUO_W; s++) begin : g_step
    logic [DEN_W:0] pull;
    logic           take;

    always_comb begin
      pull = {rem_q[s-1], low_q[s-1][QUO_W-1]};
      take = (pull >= {1'b0, den_q[s-1]});
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= take ? DEN_W'(pull - {1'b0, den_q[s-1]}) : pull[DEN_W-1:0];
        quo_q[s] <= {quo_q[s-1][QUO_W-2:0], take};
        ovf_q[s] <= ovf_q[s-1];
      end
    end

    if (s < QUO_W) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          low_q[s] <= {low_q[s-1][QUO_W-2:0], 1'b0};
          den_q[s] <= den_q[s-1];
        end
      end
    end
  end

  assign quo_o = quo_q[QUO_W];
  assign ovf_o = ovf_q[QUO_W];

endmodule

@@ rtl/triangle_incenter_2d_top.sv @@
// Top level of the triangle incenter pipeline with its register port.
//
// Channel  | Direction | Handshake              | Word
// ---------+-----------+------------------------+---------------------------------
// input    | in        | in_valid_i, in_stall_o | in_word_i: x1 y1 x2 y2 x3 y3
// output   | out       | out_valid_o, out_stall_i | out_word_o: center, flags
// config   | in        | psel, penable, pready  | paddr, pwdata, prdata
//
// One word enters per cycle unless a stalled output holds the pipeline. Each
// word passes the 32-stage square root, the 32-stage direction dividers and
// the 41-stage quotient divider. Reset clears all valid bits
// and loads the register defaults. A stalled output freezes every stage at
// once, and the input is stalled in the same cycle, so no word is lost.
module triangle_incenter_2d_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tic_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tic_pkg::out_word_t  out_word_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  import tic_pkg::*;

  localparam int unsigned RootW = 32;
  localparam int unsigned DirQW = 32;
  localparam int unsigned MdQW  = 41;

  typedef struct packed {
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic signed [31:0] cen_x;
    logic signed [31:0] cen_y;
    logic [5:0][31:0]   mag;
    logic [5:0]         neg;
    logic [2:0]         sh;
    logic signed [32:0] d12x;
    logic signed [32:0] d12y;
  } side1_t;

  typedef struct packed {
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic signed [31:0] cen_x;
    logic signed [31:0] cen_y;
    logic [5:0]         neg;
    logic signed [32:0] d12x;
    logic signed [32:0] d12y;
    logic               len_ok;
  } side2_t;

  typedef struct packed {
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic signed [31:0] cen_x;
    logic signed [31:0] cen_y;
    logic               neg_x;
    logic               neg_y;
    logic               fb;
  } side3_t;

  logic en;

  logic [MIN_EDGE_W-1:0] min_edge_q;
  logic [MIN_DET_W-1:0]  min_det_q;

  // Register port.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_edge_q <= MIN_EDGE_W'(1);
      min_det_q  <= MIN_DET_W'(11);
    end else if (psel && penable && pwrite) begin
      case (reg_idx_e'(paddr[2]))
        REG_MIN_EDGE: min_edge_q <= pwdata[MIN_EDGE_W-1:0];
        REG_MIN_DET:  min_det_q  <= pwdata[MIN_DET_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[2]))
      REG_MIN_EDGE: prdata = 32'(min_edge_q);
      REG_MIN_DET:  prdata = 32'(min_det_q);
      default:      prdata = '0;
    endcase
  end

  logic               out_valid_q;
  out_word_t          out_word_q;

  assign en          = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // Stage A: edge vectors and coordinate sums.
  logic               a_vld_q;
  logic signed [32:0] a_d_q [6];
  logic signed [31:0] a_x1_q, a_y1_q;
  logic signed [33:0] a_sx_q, a_sy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_d_q[0] <= 33'(in_word_i.x2) - 33'(in_word_i.x1);
      a_d_q[1] <= 33'(in_word_i.y2) - 33'(in_word_i.y1);
      a_d_q[2] <= 33'(in_word_i.x3) - 33'(in_word_i.x1);
      a_d_q[3] <= 33'(in_word_i.y3) - 33'(in_word_i.y1);
      a_d_q[4] <= 33'(in_word_i.x3) - 33'(in_word_i.x2);
      a_d_q[5] <= 33'(in_word_i.y3) - 33'(in_word_i.y2);
      a_x1_q   <= in_word_i.x1;
      a_y1_q   <= in_word_i.y1;
      a_sx_q   <= 34'(in_word_i.x1) + 34'(in_word_i.x2) + 34'(in_word_i.x3);
      a_sy_q   <= 34'(in_word_i.y1) + 34'(in_word_i.y2) + 34'(in_word_i.y3);
    end
  end

  // Stage B: magnitudes, range shift and centroid magnitudes.
  logic               b_vld_q;
  logic [31:0]        b_mag_q [6];
  logic [5:0]         b_neg_q;
  logic [2:0]         b_sh_q;
  logic [30:0]        b_h_q [6];
  logic [32:0]        b_sabs_q [2];
  logic [1:0]         b_sneg_q;
  logic signed [31:0] b_x1_q, b_y1_q;
  logic signed [32:0] b_d12x_q, b_d12y_q;

  logic [31:0] b_mag_d [6];
  logic [2:0]  b_sh_d;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      b_mag_d[k] = a_d_q[k][32] ? 32'(-a_d_q[k]) : a_d_q[k][31:0];
    end
    for (int e = 0; e < 3; e++) begin
      b_sh_d[e] = b_mag_d[2*e][31] | b_mag_d[2*e+1][31];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        b_mag_q[k] <= b_mag_d[k];
        b_neg_q[k] <= a_d_q[k][32];
        b_h_q[k]   <= b_sh_d[k/2] ? b_mag_d[k][31:1] : b_mag_d[k][30:0];
      end
      b_sh_q      <= b_sh_d;
      b_sabs_q[0] <= a_sx_q[33] ? 33'(-a_sx_q) : a_sx_q[32:0];
      b_sabs_q[1] <= a_sy_q[33] ? 33'(-a_sy_q) : a_sy_q[32:0];
      b_sneg_q    <= {a_sy_q[33], a_sx_q[33]};
      b_x1_q      <= a_x1_q;
      b_y1_q      <= a_y1_q;
      b_d12x_q    <= a_d_q[0];
      b_d12y_q    <= a_d_q[1];
    end
  end

  // Stage C: squares and centroid products.
  logic               c_vld_q;
  logic [61:0]        c_sq_q [6];
  logic [67:0]        c_cp_q [2];
  logic [31:0]        c_mag_q [6];
  logic [5:0]         c_neg_q;
  logic [2:0]         c_sh_q;
  logic [1:0]         c_sneg_q;
  logic signed [31:0] c_x1_q, c_y1_q;
  logic signed [32:0] c_d12x_q, c_d12y_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        c_sq_q[k]  <= 62'(b_h_q[k]) * 62'(b_h_q[k]);
        c_mag_q[k] <= b_mag_q[k];
      end
      c_cp_q[0] <= 68'(b_sabs_q[0]) * 68'(RECIP3);
      c_cp_q[1] <= 68'(b_sabs_q[1]) * 68'(RECIP3);
      c_neg_q   <= b_neg_q;
      c_sh_q    <= b_sh_q;
      c_sneg_q  <= b_sneg_q;
      c_x1_q    <= b_x1_q;
      c_y1_q    <= b_y1_q;
      c_d12x_q  <= b_d12x_q;
      c_d12y_q  <= b_d12y_q;
    end
  end

  // Edge lengths by square root, with the other fields alongside.
  side1_t      side1_d, side1_q;
  logic        s1_vld;
  logic [31:0] cq [2];
  logic [RootW-1:0] root [3];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      cq[i] = c_cp_q[i][RECIP3_SHIFT +: 32];
    end
    side1_d.x1    = c_x1_q;
    side1_d.y1    = c_y1_q;
    side1_d.cen_x = c_sneg_q[0] ? -cq[0] : cq[0];
    side1_d.cen_y = c_sneg_q[1] ? -cq[1] : cq[1];
    for (int k = 0; k < 6; k++) begin
      side1_d.mag[k] = c_mag_q[k];
    end
    side1_d.neg  = c_neg_q;
    side1_d.sh   = c_sh_q;
    side1_d.d12x = c_d12x_q;
    side1_d.d12y = c_d12y_q;
  end

  for (genvar e = 0; e < 3; e++) begin : g_len
    logic [62:0] rad;
    assign rad = 63'(c_sq_q[2*e]) + 63'(c_sq_q[2*e+1]);
    tic_isqrt #(.ROOT_W(RootW)) u_isqrt (
      .clk_i (clk_i),
      .en_i  (en),
      .rad_i ({1'b0, rad}),
      .root_o(root[e])
    );
  end

  tic_delay #(.W($bits(side1_t)), .DEPTH(RootW + 1)) u_side1 (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (c_vld_q),
    .data_i(side1_d),
    .vld_o (s1_vld),
    .data_o(side1_q)
  );

  // Unit directions by division.
  logic [32:0]      len [3];
  logic             len_ok;
  logic [DirQW-1:0] dq [6];
  side2_t           side2_d, side2_q;
  logic             s2_vld;

  always_comb begin
    len_ok = 1'b1;
    for (int e = 0; e < 3; e++) begin
      len[e] = side1_q.sh[e] ? {root[e], 1'b0} : {1'b0, root[e]};
      if (len[e] == '0 || len[e] < 33'(min_edge_q)) begin
        len_ok = 1'b0;
      end
    end
    side2_d.x1     = side1_q.x1;
    side2_d.y1     = side1_q.y1;
    side2_d.cen_x  = side1_q.cen_x;
    side2_d.cen_y  = side1_q.cen_y;
    side2_d.neg    = side1_q.neg;
    side2_d.d12x   = side1_q.d12x;
    side2_d.d12y   = side1_q.d12y;
    side2_d.len_ok = len_ok;
  end

  for (genvar k = 0; k < 6; k++) begin : g_dir
    tic_udiv #(.NUM_W(62), .DEN_W(33), .QUO_W(DirQW)) u_div (
      .clk_i(clk_i),
      .en_i (en),
      .num_i({side1_q.mag[k], 30'd0}),
      .den_i(len[k/2]),
      .quo_o(dq[k]),
      .ovf_o()
    );
  end

  tic_delay #(.W($bits(side2_t)), .DEPTH(DirQW + 1)) u_side2 (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (s1_vld),
    .data_i(side2_d),
    .vld_o (s2_vld),
    .data_o(side2_q)
  );

  // Stage F: capped signed directions in Q2.30.
  logic               f_vld_q;
  logic signed [31:0] f_r_q [6];
  side2_t             f_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        if (dq[k] > ONE_Q30) begin
          f_r_q[k] <= side2_q.neg[k] ? -ONE_Q30 : ONE_Q30;
        end else begin
          f_r_q[k] <= side2_q.neg[k] ? -dq[k] : dq[k];
        end
      end
      f_side_q <= side2_q;
    end
  end

  // Stage G: bisector normals.
  logic               g_vld_q;
  logic signed [32:0] g_a1x_q, g_a1y_q, g_a2x_q, g_a2y_q;
  side2_t             g_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_a1x_q  <= 33'(f_r_q[0]) - 33'(f_r_q[2]);
      g_a1y_q  <= 33'(f_r_q[1]) - 33'(f_r_q[3]);
      g_a2x_q  <= 33'(f_r_q[0]) + 33'(f_r_q[4]);
      g_a2y_q  <= 33'(f_r_q[1]) + 33'(f_r_q[5]);
      g_side_q <= f_side_q;
    end
  end

  // Stage H: products for the determinant and the line constant.
  logic               h_vld_q;
  logic signed [65:0] h_p_q [4];
  logic signed [32:0] h_a1x_q, h_a1y_q;
  side2_t             h_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_p_q[0] <= g_a1x_q * g_a2y_q;
      h_p_q[1] <= g_a1y_q * g_a2x_q;
      h_p_q[2] <= g_a2x_q * g_side_q.d12x;
      h_p_q[3] <= g_a2y_q * g_side_q.d12y;
      h_a1x_q  <= g_a1x_q;
      h_a1y_q  <= g_a1y_q;
      h_side_q <= g_side_q;
    end
  end

  // Stage I: determinant and line constant.
  logic               i_vld_q;
  logic signed [34:0] i_det_q;
  logic signed [35:0] i_b_q;
  logic signed [32:0] i_a1x_q, i_a1y_q;
  side2_t             i_side_q;
  logic signed [35:0] t_p [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      t_p[i] = trunc_q30(h_p_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      i_det_q  <= 35'(t_p[0]) - 35'(t_p[1]);
      i_b_q    <= t_p[2] + t_p[3];
      i_a1x_q  <= h_a1x_q;
      i_a1y_q  <= h_a1y_q;
      i_side_q <= h_side_q;
    end
  end

  // Stage J: magnitudes, quotient signs and the degenerate test.
  logic               j_vld_q;
  logic [33:0]        j_adet_q;
  logic [34:0]        j_ab_q;
  logic [31:0]        j_aa1x_q, j_aa1y_q;
  side3_t             j_side_q;
  logic [33:0]        adet_d;

  assign adet_d = i_det_q[34] ? 34'(-i_det_q) : i_det_q[33:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      j_adet_q       <= adet_d;
      j_ab_q         <= i_b_q[35] ? 35'(-i_b_q) : i_b_q[34:0];
      j_aa1x_q       <= i_a1x_q[32] ? 32'(-i_a1x_q) : i_a1x_q[31:0];
      j_aa1y_q       <= i_a1y_q[32] ? 32'(-i_a1y_q) : i_a1y_q[31:0];
      j_side_q.x1    <= i_side_q.x1;
      j_side_q.y1    <= i_side_q.y1;
      j_side_q.cen_x <= i_side_q.cen_x;
      j_side_q.cen_y <= i_side_q.cen_y;
      j_side_q.neg_x <= (!i_a1y_q[32] && i_a1y_q != '0) ^ i_b_q[35] ^ i_det_q[34];
      j_side_q.neg_y <= i_a1x_q[32] ^ i_b_q[35] ^ i_det_q[34];
      j_side_q.fb    <= !i_side_q.len_ok || i_det_q == '0 ||
                        adet_d < 34'(min_det_q);
    end
  end

  // Stage K: numerators of the offset from the first vertex.
  logic               k_vld_q;
  logic [66:0]        k_p_q [2];
  logic [33:0]        k_adet_q;
  side3_t             k_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      k_p_q[0] <= 67'(j_aa1y_q) * 67'(j_ab_q);
      k_p_q[1] <= 67'(j_aa1x_q) * 67'(j_ab_q);
      k_adet_q <= j_adet_q;
      k_side_q <= j_side_q;
    end
  end

  logic [MdQW-1:0] mq [2];
  logic [1:0]      movf;
  side3_t          side3_q;
  logic            s3_vld;

  for (genvar i = 0; i < 2; i++) begin : g_md
    tic_udiv #(.NUM_W(67), .DEN_W(34), .QUO_W(MdQW)) u_div (
      .clk_i(clk_i),
      .en_i (en),
      .num_i(k_p_q[i]),
      .den_i(k_adet_q),
      .quo_o(mq[i]),
      .ovf_o(movf[i])
    );
  end

  tic_delay #(.W($bits(side3_t)), .DEPTH(MdQW + 1)) u_side3 (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (k_vld_q),
    .data_i(k_side_q),
    .vld_o (s3_vld),
    .data_o(side3_q)
  );

  // Stage L: capped signed offsets.
  logic               l_vld_q;
  logic signed [41:0] l_u_q [2];
  side3_t             l_side_q;
  logic [MdQW-1:0]    qcap [2];
  logic [1:0]         uneg;

  assign uneg = {side3_q.neg_y, side3_q.neg_x};

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      qcap[i] = (movf[i] || mq[i] > QUOT_CAP) ? QUOT_CAP : mq[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 2; i++) begin
        l_u_q[i] <= uneg[i] ? -42'(qcap[i]) : 42'(qcap[i]);
      end
      l_side_q <= side3_q;
    end
  end

  // Output stage: add the first vertex, saturate, or take the centroid.
  localparam logic signed [42:0] SatMax = 43'sd2147483647;
  localparam logic signed [42:0] SatMin = -43'sd2147483648;

  logic signed [42:0] sum_x, sum_y;
  logic signed [31:0] res_x, res_y;
  logic               clip_x, clip_y;

  always_comb begin
    sum_x  = 43'(l_side_q.x1) + 43'(l_u_q[0]);
    sum_y  = 43'(l_side_q.y1) + 43'(l_u_q[1]);
    clip_x = 1'b1;
    clip_y = 1'b1;
    if (sum_x > SatMax) begin
      res_x = SatMax[31:0];
    end else if (sum_x < SatMin) begin
      res_x = SatMin[31:0];
    end else begin
      res_x  = sum_x[31:0];
      clip_x = 1'b0;
    end
    if (sum_y > SatMax) begin
      res_y = SatMax[31:0];
    end else if (sum_y < SatMin) begin
      res_y = SatMin[31:0];
    end else begin
      res_y  = sum_y[31:0];
      clip_y = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (l_side_q.fb) begin
        out_word_q.center_x  <= l_side_q.cen_x;
        out_word_q.center_y  <= l_side_q.cen_y;
        out_word_q.fell_back <= 1'b1;
        out_word_q.saturated <= 1'b0;
      end else begin
        out_word_q.center_x  <= res_x;
        out_word_q.center_y  <= res_y;
        out_word_q.fell_back <= 1'b0;
        out_word_q.saturated <= clip_x | clip_y;
      end
    end
  end

  // Valid bits of the stage registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q     <= 1'b0;
      b_vld_q     <= 1'b0;
      c_vld_q     <= 1'b0;
      f_vld_q     <= 1'b0;
      g_vld_q     <= 1'b0;
      h_vld_q     <= 1'b0;
      i_vld_q     <= 1'b0;
      j_vld_q     <= 1'b0;
      k_vld_q     <= 1'b0;
      l_vld_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      a_vld_q     <= in_valid_i;
      b_vld_q     <= a_vld_q;
      c_vld_q     <= b_vld_q;
      f_vld_q     <= s2_vld;
      g_vld_q     <= f_vld_q;
      h_vld_q     <= g_vld_q;
      i_vld_q     <= h_vld_q;
      j_vld_q     <= i_vld_q;
      k_vld_q     <= j_vld_q;
      l_vld_q     <= s3_vld;
      out_valid_q <= l_vld_q;
    end
  end

endmodule
